>>> rtl/core/mtk_pkg.sv
// Shared types, constants and the Morse symbol table of the text keyer.
package mtk_pkg;

  localparam int FIFO_DEPTH_DEF = 32;
  localparam int UNIT_W = 11;
  localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 11'd60;

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic       new_message;
  } in_item_t;

  typedef struct packed {
    logic key_down;
    logic busy_res;
    logic dropped;
  } out_item_t;

  // A known symbol with length zero is the word space.
  typedef struct packed {
    logic       known;
    logic [2:0] len;
    logic [6:0] bits;
  } sym_t;

  typedef struct packed {
    logic       push;
    logic       push_nm;
    sym_t       push_sym;
    logic       pop_grp;
    logic       clr_grp;
    logic       pop_pend;
    logic       clr_pend;
    logic       flush;
  } q_cmd_t;

  typedef struct packed {
    logic       full;
    logic       grp_valid;
    logic       grp_mark;
    logic [2:0] grp_len;
    logic [6:0] grp_bits;
    logic       pend_valid;
    logic       pend_mark;
  } q_stat_t;

  // The pattern is written in reading order, dot 0 and dash 1; the first element
  // lands in bit 0.
  function automatic sym_t mk_sym(input logic [2:0] len, input logic [6:0] pat);
    sym_t s;
    s.known = 1'b1;
    s.len   = len;
    s.bits  = '0;
    for (int k = 0; k < 7; k++) begin
      if (k < int'(len)) begin
        s.bits[k] = pat[int'(len) - 1 - k];
      end
    end
    return s;
  endfunction

  function automatic sym_t sym_lookup(input logic [7:0] code);
    logic [7:0] c;
    sym_t s;
    c = code;
    if (code >= "a" && code <= "z") begin
      c = code - 8'd32;
    end
    s = '0;
    case (c)
      " ": s.known = 1'b1;
      "A": s = mk_sym(3'd2, 7'b01);
      "B": s = mk_sym(3'd4, 7'b1000);
      "C": s = mk_sym(3'd4, 7'b1010);
      "D": s = mk_sym(3'd3, 7'b100);
      "E": s = mk_sym(3'd1, 7'b0);
      "F": s = mk_sym(3'd4, 7'b0010);
      "G": s = mk_sym(3'd3, 7'b110);
      "H": s = mk_sym(3'd4, 7'b0000);
      "I": s = mk_sym(3'd2, 7'b00);
      "J": s = mk_sym(3'd4, 7'b0111);
      "K": s = mk_sym(3'd3, 7'b101);
      "L": s = mk_sym(3'd4, 7'b0100);
      "M": s = mk_sym(3'd2, 7'b11);
      "N": s = mk_sym(3'd2, 7'b10);
      "O": s = mk_sym(3'd3, 7'b111);
      "P": s = mk_sym(3'd4, 7'b0110);
      "Q": s = mk_sym(3'd4, 7'b1101);
      "R": s = mk_sym(3'd3, 7'b010);
      "S": s = mk_sym(3'd3, 7'b000);
      "T": s = mk_sym(3'd1, 7'b1);
      "U": s = mk_sym(3'd3, 7'b001);
      "V": s = mk_sym(3'd4, 7'b0001);
      "W": s = mk_sym(3'd3, 7'b011);
      "X": s = mk_sym(3'd4, 7'b1001);
      "Y": s = mk_sym(3'd4, 7'b1011);
      "Z": s = mk_sym(3'd4, 7'b1100);
      "0": s = mk_sym(3'd5, 7'b11111);
      "1": s = mk_sym(3'd5, 7'b01111);
      "2": s = mk_sym(3'd5, 7'b00111);
      "3": s = mk_sym(3'd5, 7'b00011);
      "4": s = mk_sym(3'd5, 7'b00001);
      "5": s = mk_sym(3'd5, 7'b00000);
      "6": s = mk_sym(3'd5, 7'b10000);
      "7": s = mk_sym(3'd5, 7'b11000);
      "8": s = mk_sym(3'd5, 7'b11100);
      "9": s = mk_sym(3'd5, 7'b11110);
      ".": s = mk_sym(3'd6, 7'b010101);
      ",": s = mk_sym(3'd6, 7'b110011);
      "?": s = mk_sym(3'd6, 7'b001100);
      "'": s = mk_sym(3'd6, 7'b011110);
      "!": s = mk_sym(3'd6, 7'b101011);
      "/": s = mk_sym(3'd5, 7'b10010);
      "(": s = mk_sym(3'd5, 7'b10110);
      ")": s = mk_sym(3'd6, 7'b101101);
      "&": s = mk_sym(3'd5, 7'b01000);
      ":": s = mk_sym(3'd6, 7'b111000);
      ";": s = mk_sym(3'd6, 7'b101010);
      "=": s = mk_sym(3'd5, 7'b10001);
      "+": s = mk_sym(3'd5, 7'b01010);
      "-": s = mk_sym(3'd6, 7'b100001);
      "_": s = mk_sym(3'd6, 7'b001101);
      "\"": s = mk_sym(3'd6, 7'b010010);
      "$": s = mk_sym(3'd7, 7'b0001001);
      "@": s = mk_sym(3'd6, 7'b011010);
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/mtk_chan_if.sv
// Valid/ready channel interface carrying one item of a given payload type.
interface mtk_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/mtk_queue.sv
// Character store: memory of symbol groups with pending unknown-character bookkeeping.
module mtk_queue #(
  parameter int FIFO_DEPTH = mtk_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mtk_pkg::q_cmd_t cmd_i,
  output mtk_pkg::q_stat_t stat_o
);
  import mtk_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

  // Each entry is one keyable character together with the unknown characters
  // queued ahead of it: n counts them, pre counts those before the first mark.
  typedef struct packed {
    logic [AW-1:0] pre;
    logic [AW-1:0] n;
    logic          mark;
    logic [2:0]    len;
    logic [6:0]    bits;
  } entry_t;

  entry_t        mem_q [FIFO_DEPTH];
  entry_t        rd_data_q;
  entry_t        wentry;
  logic          we;
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] grp_cnt_q, grp_cnt_d, fill_q, fill_d, dec;
  logic [CW-1:0] pend_n_q, pend_n_d, pend_pre_q, pend_pre_d;
  logic          pend_mark_q, pend_mark_d, hd_clr_q, hd_clr_d;

  always_comb begin
    wentry.pre  = pend_mark_q ? pend_pre_q[AW-1:0] : pend_n_q[AW-1:0];
    wentry.n    = pend_n_q[AW-1:0];
    wentry.mark = pend_mark_q | cmd_i.push_nm;
    wentry.len  = cmd_i.push_sym.len;
    wentry.bits = cmd_i.push_sym.bits;
    we = cmd_i.push && cmd_i.push_sym.known;
  end

  always_comb begin
    priority if (cmd_i.pop_grp) begin
      dec = CW'(rd_data_q.n) - (hd_clr_q ? CW'(rd_data_q.pre) : '0) + CW'(1);
    end else if (cmd_i.clr_grp) begin
      dec = CW'(rd_data_q.pre);
    end else if (cmd_i.pop_pend) begin
      dec = pend_n_q;
    end else if (cmd_i.clr_pend) begin
      dec = pend_pre_q;
    end else begin
      dec = '0;
    end
  end

  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    grp_cnt_d   = grp_cnt_q;
    pend_n_d    = pend_n_q;
    pend_pre_d  = pend_pre_q;
    pend_mark_d = pend_mark_q;
    hd_clr_d    = hd_clr_q;
    fill_d      = fill_q + CW'(cmd_i.push) - dec;
    if (cmd_i.flush) begin
      wr_ptr_d    = '0;
      rd_ptr_d    = '0;
      grp_cnt_d   = '0;
      pend_n_d    = '0;
      pend_pre_d  = '0;
      pend_mark_d = 1'b0;
      hd_clr_d    = 1'b0;
      fill_d      = '0;
    end else begin
      if (cmd_i.push) begin
        if (cmd_i.push_sym.known) begin
          wr_ptr_d    = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
          grp_cnt_d   = grp_cnt_q + CW'(1);
          pend_n_d    = '0;
          pend_pre_d  = '0;
          pend_mark_d = 1'b0;
        end else begin
          pend_n_d = pend_n_q + CW'(1);
          if (cmd_i.push_nm && !pend_mark_q) begin
            pend_mark_d = 1'b1;
            pend_pre_d  = pend_n_q;
          end
        end
      end
      if (cmd_i.pop_grp) begin
        rd_ptr_d  = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
        grp_cnt_d = grp_cnt_q - CW'(1);
        hd_clr_d  = 1'b0;
      end
      if (cmd_i.clr_grp) begin
        hd_clr_d = 1'b1;
      end
      if (cmd_i.pop_pend) begin
        pend_n_d    = '0;
        pend_pre_d  = '0;
        pend_mark_d = 1'b0;
      end
      if (cmd_i.clr_pend) begin
        pend_n_d    = pend_n_q - pend_pre_q;
        pend_pre_d  = '0;
        pend_mark_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      grp_cnt_q   <= '0;
      fill_q      <= '0;
      pend_n_q    <= '0;
      pend_pre_q  <= '0;
      pend_mark_q <= 1'b0;
      hd_clr_q    <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      grp_cnt_q   <= grp_cnt_d;
      fill_q      <= fill_d;
      pend_n_q    <= pend_n_d;
      pend_pre_q  <= pend_pre_d;
      pend_mark_q <= pend_mark_d;
      hd_clr_q    <= hd_clr_d;
    end
  end

  // The read port follows the next head address; a write to that address in the
  // same cycle is forwarded into the read register.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_ptr_q] <= wentry;
    end
    if (we && (wr_ptr_q == rd_ptr_d)) begin
      rd_data_q <= wentry;
    end else begin
      rd_data_q <= mem_q[rd_ptr_d];
    end
  end

  always_comb begin
    stat_o.full       = (fill_q == CW'(FIFO_DEPTH));
    stat_o.grp_valid  = (grp_cnt_q != '0);
    stat_o.grp_mark   = rd_data_q.mark & ~hd_clr_q;
    stat_o.grp_len    = rd_data_q.len;
    stat_o.grp_bits   = rd_data_q.bits;
    stat_o.pend_valid = (pend_n_q != '0);
    stat_o.pend_mark  = pend_mark_q;
  end

endmodule

>>> rtl/core/mtk_seq.sv
// Element sequencer: command decode, element timing and the key gate.
module mtk_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mtk_pkg::UNIT_W-1:0]  cfg_data_i,
  input  logic                        fire_i,
  input  mtk_pkg::in_item_t           item_i,
  input  mtk_pkg::q_stat_t            stat_i,
  output mtk_pkg::q_cmd_t             qcmd_o,
  output mtk_pkg::out_item_t          res_o
);
  import mtk_pkg::*;

  localparam int TW = 13;

  localparam logic [2:0] K_IDLE = 3'd0;
  localparam logic [2:0] K_DIT  = 3'd1;
  localparam logic [2:0] K_DAH  = 3'd2;
  localparam logic [2:0] K_EGAP = 3'd3;
  localparam logic [2:0] K_CGAP = 3'd4;
  localparam logic [2:0] K_WGAP = 3'd5;

  logic [UNIT_W-1:0] unit_q, unit_eff;
  logic [2:0]        kind_q, kind_d, sl_q, sl_d, pos_q, pos_d;
  logic [6:0]        bits_q, bits_d;
  logic [TW-1:0]     ticks_q, ticks_d;
  logic              gate_q, gate_d, active_q, active_d, first_q, first_d;
  logic              start, do_fetch, go_idle, dropped, fe;
  logic [2:0]        start_kind;
  sym_t              sym_in;

  function automatic logic [TW-1:0] elem_ticks(input logic [2:0] kind,
                                               input logic [UNIT_W-1:0] u);
    logic [TW-1:0] w;
    w = TW'(u);
    unique case (kind)
      K_DIT, K_EGAP: return w;
      K_DAH, K_CGAP: return (w << 1) + w;
      K_WGAP:        return w << 2;
      default:       return '0;
    endcase
  endfunction

  assign unit_eff = (unit_q == '0) ? UNIT_W'(1) : unit_q;
  assign sym_in   = sym_lookup(item_i.char_code);

  always_comb begin
    kind_d     = kind_q;
    sl_d       = sl_q;
    pos_d      = pos_q;
    bits_d     = bits_q;
    ticks_d    = ticks_q;
    gate_d     = gate_q;
    active_d   = active_q;
    first_d    = first_q;
    qcmd_o     = '0;
    dropped    = 1'b0;
    start      = 1'b0;
    start_kind = K_IDLE;
    do_fetch   = 1'b0;
    go_idle    = 1'b0;
    fe         = 1'b0;

    if (fire_i) begin
      unique case (item_i.cmd)
        CMD_ENQ: begin
          if (active_q) begin
            if (stat_i.full) begin
              dropped = 1'b1;
            end else begin
              qcmd_o.push     = 1'b1;
              qcmd_o.push_nm  = item_i.new_message;
              qcmd_o.push_sym = sym_in;
            end
          end else if (sym_in.known) begin
            // The keyer is idle, so the character is keyed at once.
            start = 1'b1;
            if (sym_in.len == '0) begin
              start_kind = K_WGAP;
              sl_d       = '0;
              pos_d      = '0;
            end else begin
              bits_d     = sym_in.bits;
              sl_d       = sym_in.len;
              first_d    = 1'b0;
              start_kind = sym_in.bits[0] ? K_DAH : K_DIT;
              pos_d      = 3'd1;
            end
          end
        end
        CMD_TICK: begin
          if (active_q) begin
            if (ticks_q > TW'(1)) begin
              ticks_d = ticks_q - TW'(1);
            end else if (pos_q < sl_q) begin
              start = 1'b1;
              if (kind_q == K_DIT || kind_q == K_DAH) begin
                start_kind = K_EGAP;
              end else begin
                start_kind = bits_q[pos_q] ? K_DAH : K_DIT;
                pos_d      = pos_q + 3'd1;
              end
            end else begin
              do_fetch = 1'b1;
            end
          end
        end
        CMD_STOP: begin
          qcmd_o.flush = 1'b1;
          go_idle      = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (do_fetch) begin
      if (stat_i.grp_valid) begin
        if (stat_i.grp_mark && gate_q) begin
          qcmd_o.clr_grp = 1'b1;
          first_d        = 1'b1;
          start          = 1'b1;
          start_kind     = K_CGAP;
          sl_d           = '0;
          pos_d          = '0;
        end else begin
          qcmd_o.pop_grp = 1'b1;
          fe             = first_q | stat_i.grp_mark;
          start          = 1'b1;
          if (stat_i.grp_len == '0) begin
            start_kind = K_WGAP;
            sl_d       = '0;
            pos_d      = '0;
            first_d    = fe;
          end else begin
            bits_d  = stat_i.grp_bits;
            sl_d    = stat_i.grp_len;
            first_d = 1'b0;
            if (!fe) begin
              start_kind = K_CGAP;
              pos_d      = '0;
            end else begin
              start_kind = stat_i.grp_bits[0] ? K_DAH : K_DIT;
              pos_d      = 3'd1;
            end
          end
        end
      end else if (stat_i.pend_valid && stat_i.pend_mark && gate_q) begin
        qcmd_o.clr_pend = 1'b1;
        first_d         = 1'b1;
        start           = 1'b1;
        start_kind      = K_CGAP;
        sl_d            = '0;
        pos_d           = '0;
      end else begin
        qcmd_o.pop_pend = stat_i.pend_valid;
        go_idle         = 1'b1;
      end
    end

    if (go_idle) begin
      kind_d   = K_IDLE;
      ticks_d  = '0;
      gate_d   = 1'b0;
      active_d = 1'b0;
      first_d  = 1'b1;
      sl_d     = '0;
      pos_d    = '0;
      bits_d   = '0;
    end

    if (start) begin
      kind_d   = start_kind;
      ticks_d  = elem_ticks(start_kind, unit_eff);
      gate_d   = (start_kind == K_DIT) || (start_kind == K_DAH);
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q   <= UNIT_TICKS_RESET;
      kind_q   <= K_IDLE;
      sl_q     <= '0;
      pos_q    <= '0;
      bits_q   <= '0;
      ticks_q  <= '0;
      gate_q   <= 1'b0;
      active_q <= 1'b0;
      first_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        unit_q <= cfg_data_i;
      end
      kind_q   <= kind_d;
      sl_q     <= sl_d;
      pos_q    <= pos_d;
      bits_q   <= bits_d;
      ticks_q  <= ticks_d;
      gate_q   <= gate_d;
      active_q <= active_d;
      first_q  <= first_d;
    end
  end

  // While idle the store is always empty, so busy follows the active flag.
  always_comb begin
    res_o.key_down = gate_d;
    res_o.busy_res = active_d;
    res_o.dropped  = dropped;
  end

endmodule

>>> rtl/core/mtk_obuf.sv
// Two-entry result buffer between the sequencer and the output channel.
module mtk_obuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mtk_pkg::out_item_t data_i,
  output logic               ready_o,
  output logic               valid_o,
  output mtk_pkg::out_item_t data_o,
  input  logic               ready_i
);
  import mtk_pkg::*;

  out_item_t  slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d, wsel;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && ready_i;
  assign wsel    = cnt_q - {1'b0, pop};
  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot0_q;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) begin
      slot0_d = slot1_q;
    end
    if (push_i && wsel == 2'd0) begin
      slot0_d = data_i;
    end
    if (push_i && wsel == 2'd1) begin
      slot1_d = data_i;
    end
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

>>> rtl/core/morse_text_keyer.sv
// Top level of the Morse text keyer.
// The keyer takes one item per clock and answers every item with one result
// item, the key gate, busy and drop flags as they stand after that item. The
// result enters a two-entry output buffer in the cycle the item is accepted,
// so input is refused only while that buffer holds two results. Characters
// are held in a memory of FIFO_DEPTH entries with one write and one registered
// read per cycle; the head entry is read ahead so that consecutive characters
// can be fetched in consecutive cycles. The memory needs no clearing after
// reset. The user is to set the Morse unit in ticks (cfg_we_i, cfg_data_i)
// only while the keyer is idle; the block does not enforce it. Zero acts as one.
module morse_text_keyer #(
  parameter int FIFO_DEPTH = mtk_pkg::FIFO_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mtk_pkg::UNIT_W-1:0] cfg_data_i,
  mtk_chan_if.sink                   in_i,
  mtk_chan_if.source                 out_o
);
  import mtk_pkg::*;

  logic      fire;
  logic      buf_ready;
  in_item_t  item;
  q_cmd_t    qcmd;
  q_stat_t   qstat;
  out_item_t res;
  out_item_t out_data;

  assign in_i.ready = buf_ready;
  assign fire       = in_i.valid && buf_ready;
  assign item       = in_i.data;

  mtk_queue #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (qcmd),
    .stat_o (qstat)
  );

  mtk_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (item),
    .stat_i     (qstat),
    .qcmd_o     (qcmd),
    .res_o      (res)
  );

  mtk_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .data_i  (res),
    .ready_o (buf_ready),
    .valid_o (out_o.valid),
    .data_o  (out_data),
    .ready_i (out_o.ready)
  );

  assign out_o.data = out_data;

endmodule

>>> verif/tb_morse_text_keyer.sv
// Self-checking testbench of the Morse text keyer: directed table, random text and tick streams.
module tb_morse_text_keyer;
  import mtk_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES = 12;
  localparam logic [UNIT_W-1:0] PHASE_UNIT [NUM_PHASES] =
    '{11'd3, 11'd1, 11'd2, 11'd1200, 11'd1, 11'd0, 11'd6, 11'd2047, 11'd2, 11'd1, 11'd4, 11'd1};

  typedef enum logic [2:0] {EL_IDLE, EL_DIT, EL_DAH, EL_EGAP, EL_CGAP, EL_WGAP} elem_e;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [1:0]        cmd;
    logic [7:0]        ch;
    logic              nm;
    logic [7:0]        reps;
    logic              typed;
    out_item_t         want;
    logic [UNIT_W-1:0] unit;
  } dir_row_t;

  localparam int NUM_ROWS = 20;
  localparam dir_row_t PLAN [NUM_ROWS] = '{
    '{ROW_ITEM, CMD_TICK, 8'h00, 1'b0, 8'd1,  1'b1, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_NONE, 8'hFF, 1'b1, 8'd1,  1'b1, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_STOP, 8'h55, 1'b1, 8'd1,  1'b1, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_ENQ,  "T",   1'b1, 8'd1,  1'b1, 3'b110, 11'd0},
    '{ROW_ITEM, CMD_ENQ,  "t",   1'b0, 8'd32, 1'b0, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_ENQ,  "T",   1'b0, 8'd1,  1'b1, 3'b111, 11'd0},
    '{ROW_ITEM, CMD_STOP, 8'h00, 1'b0, 8'd1,  1'b1, 3'b000, 11'd0},
    '{ROW_CFG,  CMD_NONE, 8'h00, 1'b0, 8'd0,  1'b0, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_ENQ,  "E",   1'b1, 8'd1,  1'b1, 3'b110, 11'd0},
    '{ROW_ITEM, CMD_TICK, 8'hAA, 1'b0, 8'd1,  1'b1, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_ENQ,  "a",   1'b1, 8'd1,  1'b0, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_ENQ,  8'h80, 1'b1, 8'd1,  1'b0, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_ENQ,  " ",   1'b0, 8'd1,  1'b0, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_ENQ,  "$",   1'b0, 8'd1,  1'b0, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_ENQ,  "5",   1'b1, 8'd1,  1'b0, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_TICK, 8'h00, 1'b0, 8'd60, 1'b0, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_ENQ,  "@",   1'b0, 8'd1,  1'b0, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_ENQ,  "z",   1'b0, 8'd1,  1'b0, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_TICK, 8'hFF, 1'b1, 8'd30, 1'b0, 3'b000, 11'd0},
    '{ROW_ITEM, CMD_STOP, 8'h00, 1'b0, 8'd1,  1'b1, 3'b000, 11'd0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [UNIT_W-1:0] cfg_data;

  mtk_chan_if #(.T(in_item_t))  in_ch ();
  mtk_chan_if #(.T(out_item_t)) out_ch ();

  morse_text_keyer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  out_item_t expected_keying [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        quiet_cycles = 0;
  bit        steady = 1'b0;
  bit        hold_req = 1'b0;
  string     text_pool =
    "ETAOINSHRDLUCMFWYPVBGKQJXZ etaoin shrdlu cmfwyp 0123456789.,?'!/()&:;=+-_\"$@ ";

  logic [UNIT_W-1:0] unit_q;
  logic [8:0]        m_fifo [FIFO_DEPTH_DEF];
  logic [4:0]        m_rd, m_wr;
  logic [5:0]        m_count;
  logic [6:0]        m_pattern;
  logic [2:0]        m_len, m_pos;
  elem_e             m_elem;
  logic [12:0]       m_ticks;
  logic              m_gate, m_run, m_msg_start;

  function automatic string morse_code(input logic [7:0] c);
    case (c)
      "A": return ".-";     "B": return "-...";   "C": return "-.-.";   "D": return "-..";
      "E": return ".";      "F": return "..-.";   "G": return "--.";    "H": return "....";
      "I": return "..";     "J": return ".---";   "K": return "-.-";    "L": return ".-..";
      "M": return "--";     "N": return "-.";     "O": return "---";    "P": return ".--.";
      "Q": return "--.-";   "R": return ".-.";    "S": return "...";    "T": return "-";
      "U": return "..-";    "V": return "...-";   "W": return ".--";    "X": return "-..-";
      "Y": return "-.--";   "Z": return "--..";
      "0": return "-----";  "1": return ".----";  "2": return "..---";  "3": return "...--";
      "4": return "....-";  "5": return ".....";  "6": return "-....";  "7": return "--...";
      "8": return "---..";  "9": return "----.";
      ".": return ".-.-.-"; ",": return "--..--"; "?": return "..--.."; "'": return ".----.";
      "!": return "-.-.--"; "/": return "-..-.";  "(": return "-.--.";  ")": return "-.--.-";
      "&": return ".-...";  ":": return "---..."; ";": return "-.-.-."; "=": return "-...-";
      "+": return ".-.-.";  "-": return "-....-"; "_": return "..--.-"; "\"": return ".-..-.";
      "$": return "...-..-"; "@": return ".--.-.";
      default: return "";
    endcase
  endfunction

  task automatic clear_keyer();
    m_rd = '0;
    m_wr = '0;
    m_count = '0;
    m_pattern = '0;
    m_len = '0;
    m_pos = '0;
    m_elem = EL_IDLE;
    m_ticks = '0;
    m_gate = 1'b0;
    m_run = 1'b0;
    m_msg_start = 1'b1;
  endtask

  task automatic start_elem(input elem_e k);
    int u;
    u = (unit_q == '0) ? 1 : int'(unit_q);
    m_elem = k;
    case (k)
      EL_DIT, EL_EGAP: m_ticks = 13'(u);
      EL_DAH, EL_CGAP: m_ticks = 13'(3 * u);
      EL_WGAP:         m_ticks = 13'(4 * u);
      default:         m_ticks = '0;
    endcase
    m_gate = (k == EL_DIT || k == EL_DAH);
    m_run = 1'b1;
  endtask

  task automatic start_mark(input logic [2:0] pos);
    start_elem(m_pattern[pos] ? EL_DAH : EL_DIT);
  endtask

  task automatic fetch_char(output bit got);
    logic [8:0] e;
    logic [7:0] c;
    string      code;
    got = 1'b0;
    while (m_count != 0 && !got) begin
      e = m_fifo[m_rd];
      if (e[8]) begin
        m_msg_start = 1'b1;
        if (m_gate) begin
          m_fifo[m_rd] = {1'b0, e[7:0]};
          m_len = '0;
          m_pos = '0;
          start_elem(EL_CGAP);
          got = 1'b1;
        end
      end
      if (!got) begin
        m_rd = m_rd + 5'd1;
        m_count = m_count - 6'd1;
        c = e[7:0];
        if (c >= "a" && c <= "z") c = c - 8'd32;
        if (c == " ") begin
          m_len = '0;
          m_pos = '0;
          start_elem(EL_WGAP);
          got = 1'b1;
        end else begin
          code = morse_code(c);
          if (code.len() > 0) begin
            m_pattern = '0;
            for (int k = 0; k < code.len(); k++) begin
              if (code[k] == "-") m_pattern[k] = 1'b1;
            end
            m_len = 3'(code.len());
            if (!m_msg_start) begin
              m_pos = '0;
              start_elem(EL_CGAP);
            end else begin
              m_msg_start = 1'b0;
              start_mark(3'd0);
              m_pos = 3'd1;
            end
            got = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic next_element();
    bit got;
    if (m_pos < m_len) begin
      if (m_elem == EL_DIT || m_elem == EL_DAH) begin
        start_elem(EL_EGAP);
      end else begin
        start_mark(m_pos);
        m_pos = m_pos + 3'd1;
      end
    end else begin
      fetch_char(got);
      if (!got) begin
        clear_keyer();
      end
    end
  endtask

  task automatic keyer_step(input in_item_t it, output out_item_t res);
    bit drop;
    drop = 1'b0;
    case (it.cmd)
      CMD_ENQ: begin
        if (m_count >= FIFO_DEPTH_DEF) begin
          drop = 1'b1;
        end else begin
          m_fifo[m_wr] = {it.new_message, it.char_code};
          m_wr = m_wr + 5'd1;
          m_count = m_count + 6'd1;
          if (!m_run) next_element();
        end
      end
      CMD_TICK: begin
        if (m_run) begin
          if (m_ticks > 13'd1) m_ticks = m_ticks - 13'd1;
          else next_element();
        end
      end
      CMD_STOP: clear_keyer();
      default: ;
    endcase
    res.key_down = m_gate;
    res.busy_res = m_run || (m_count != 0);
    res.dropped = drop;
  endtask

  task automatic report_mismatch(input string what, input logic got, input logic want);
    if (mismatches < 50) begin
      $display("mismatch on result %0d: %s is %0b, expected %0b", results_seen, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_keying.size() == 0) begin
        report_mismatch("unexpected item", 1'b1, 1'b0);
      end else begin
        want = expected_keying.pop_front();
        if (out_ch.data.key_down !== want.key_down)
          report_mismatch("key_down", out_ch.data.key_down, want.key_down);
        if (out_ch.data.busy_res !== want.busy_res)
          report_mismatch("busy_res", out_ch.data.busy_res, want.busy_res);
        if (out_ch.data.dropped !== want.dropped)
          report_mismatch("dropped", out_ch.data.dropped, want.dropped);
      end
      results_seen++;
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("** morse_text_keyer: FAILED **");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (149) @(posedge clk_i);
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    keyer_step(it, pred);
    expected_keying.push_back(typed ? want : pred);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_keying.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_unit(input logic [UNIT_W-1:0] value);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    unit_q = value;
  endtask

  function automatic in_item_t char_item();
    in_item_t it;
    it.cmd = CMD_ENQ;
    it.new_message = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) < 8) it.char_code = text_pool[$urandom_range(0, text_pool.len() - 1)];
    else it.char_code = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t next_random_item();
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 8) return char_item();
    it.char_code = 8'($urandom_range(0, 255));
    it.new_message = 1'($urandom_range(0, 1));
    if (r < 96) it.cmd = CMD_TICK;
    else if (r < 98) it.cmd = CMD_STOP;
    else it.cmd = CMD_NONE;
    return it;
  endfunction

  // Short units are ticked out toward the natural end of the run; whatever still runs after that is stopped.
  task automatic settle_keyer();
    in_item_t it;
    int       n;
    n = 0;
    if (unit_q <= 11'd8) begin
      while ((m_run || m_count != 0) && n < 40) begin
        it = next_random_item();
        it.cmd = CMD_TICK;
        send_item(it, 1'b0, '0);
        n++;
      end
    end
    if (m_run || m_count != 0) begin
      it = next_random_item();
      it.cmd = CMD_STOP;
      send_item(it, 1'b0, '0);
    end
  endtask

  initial begin
    in_item_t row_item;
    int       n_items;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    unit_q = UNIT_TICKS_RESET;
    clear_keyer();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        write_unit(PLAN[i].unit);
      end else begin
        row_item.cmd = PLAN[i].cmd;
        row_item.char_code = PLAN[i].ch;
        row_item.new_message = PLAN[i].nm;
        repeat (PLAN[i].reps) send_item(row_item, PLAN[i].typed, PLAN[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_unit(PHASE_UNIT[p]);
      if (p == 1) hold_req = 1'b1;
      if (p == NUM_PHASES - 1) steady = 1'b1;
      n_items = (PHASE_UNIT[p] >= 11'd100) ? 20 : 60;
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) == 0) begin
          repeat (36) send_item(char_item(), 1'b0, '0);
        end else begin
          send_item(next_random_item(), 1'b0, '0);
        end
      end
      settle_keyer();
    end

    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** morse_text_keyer: PASSED **");
    end else begin
      $display("** morse_text_keyer: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mtk_pkg.sv
rtl/core/mtk_chan_if.sv
rtl/core/mtk_queue.sv
rtl/core/mtk_seq.sv
rtl/core/mtk_obuf.sv
rtl/core/morse_text_keyer.sv
verif/tb_morse_text_keyer.sv
